@@ hdl/chained_hash_set_engine_macros.svh @@
// assertion macros for the chained hash set engine
`ifndef CHAINED_HASH_SET_ENGINE_MACROS_SVH
`define CHAINED_HASH_SET_ENGINE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants and hash remix function of the chained hash set engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

	localparam int unsigned BUCKETS_DEF = 1024;
	localparam int unsigned NODES_DEF = 4096;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned CNT_W = 13;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;

	// remix of one 32-bit half
	function automatic logic [31:0] mix_half(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 15) ^ (h >> 23);
		return t ^ (t >> 7) ^ (t >> 5);
	endfunction

endpackage

`default_nettype wire

@@ hdl/chained_hash_set_engine.sv @@
// ----------------------------------------------------------------------------
// chained_hash_set_engine
// Set of 64-bit keys in separate chains over a fixed node pool.
// ----------------------------------------------------------------------------
//  channel   | handshake            | fields
//  request   | start & !busy        | cmd, key
//  result    | done strobe, 1 cycle | found, changed, full_res, entry_count
//
//  After reset the bucket heads are cleared, one a cycle, while busy is high.
//  An item runs through hashing and head read, then one link/key memory
//  read per chain node visited, then the finish: end of chain check, a
//  free list read on a recycled add, update, done.
//  One memory port per store sets the pace; done is registered from ST_DONE.
//  The receiver cannot stall; busy is already low in the done cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_set_engine_macros.svh"

module chained_hash_set_engine #(
	parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
	parameter int unsigned NODES = chs_pkg::NODES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] cmd,
	input wire logic [63:0] key,
	output logic done,
	output logic found,
	output logic changed,
	output logic full_res,
	output logic [12:0] entry_count
);

	localparam int unsigned BW = $clog2(BUCKETS);
	localparam int unsigned NW = $clog2(NODES) + 1;   // holds null marker NODES
	localparam int unsigned AW = $clog2(NODES);
	localparam logic [NW-1:0] NULLN = NW'(NODES);

	typedef enum logic [11:0] {
		ST_CLEAR = 12'b000000000001,
		ST_IDLE = 12'b000000000010,
		ST_HASH = 12'b000000000100,
		ST_HRD = 12'b000000001000,
		ST_HWAIT = 12'b000000010000,
		ST_NRD = 12'b000000100000,
		ST_NCMP = 12'b000001000000,
		ST_ACT = 12'b000010000000,
		ST_FRD = 12'b000100000000,
		ST_FWAIT = 12'b001000000000,
		ST_WR2 = 12'b010000000000,
		ST_DONE = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [1:0] cmd_q;
	logic [63:0] key_q;
	logic [BW-1:0] bkt_q;
	logic [NW-1:0] cur_q, prev_q, hit_q, nxt_q, newn_q;
	logic [NW-1:0] free_q, fresh_q;
	logic [12:0] cnt_q;
	logic [NW:0] steps_q;
	logic found_q, chg_q, full_q;

	// memory ports
	logic hb_we, nk_we, nl_we;
	logic [BW-1:0] hb_addr;
	logic [AW-1:0] nk_addr, nl_addr;
	logic [NW-1:0] hb_wd, hb_rd, nl_wd, nl_rd;
	logic [63:0] nk_rd;

	chs_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(hb_we), .addr(hb_addr), .wdata(hb_wd), .rdata(hb_rd));
	chs_ram #(.WIDTH(64), .DEPTH(NODES)) u_key (
		.clk(clk), .we(nk_we), .addr(nk_addr), .wdata(key_q), .rdata(nk_rd));
	chs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link (
		.clk(clk), .we(nl_we), .addr(nl_addr), .wdata(nl_wd), .rdata(nl_rd));

	logic [31:0] hmix;
	assign hmix = chs_pkg::mix_half(key_q[63:32]) ^ chs_pkg::mix_half(key_q[31:0]);

	logic is_add, is_rem;
	assign is_add = (cmd_q == chs_pkg::CMD_ADD);
	assign is_rem = (cmd_q == chs_pkg::CMD_REMOVE);

	// memory port control per state
	always_comb begin
		hb_we = 1'b0; nk_we = 1'b0; nl_we = 1'b0;
		hb_addr = bkt_q; hb_wd = NULLN;
		nk_addr = cur_q[AW-1:0]; nl_addr = cur_q[AW-1:0]; nl_wd = NULLN;
		case (state_q)
			ST_CLEAR: begin
				hb_we = 1'b1;
			end
			ST_ACT: begin
				if (is_add && !found_q && newn_q != NULLN) begin
					// write new node, then link it in ST_WR2
					nk_we = 1'b1; nl_we = 1'b1;
					nk_addr = newn_q[AW-1:0]; nl_addr = newn_q[AW-1:0];
				end else if (is_rem && found_q) begin
					// unlink the hit
					if (prev_q == NULLN) begin
						hb_we = 1'b1; hb_wd = nxt_q;
					end else begin
						nl_we = 1'b1; nl_addr = prev_q[AW-1:0]; nl_wd = nxt_q;
					end
				end
			end
			ST_WR2: begin
				if (is_add) begin
					if (prev_q == NULLN) begin
						hb_we = 1'b1; hb_wd = newn_q;
					end else begin
						nl_we = 1'b1; nl_addr = prev_q[AW-1:0]; nl_wd = newn_q;
					end
				end else begin
					nl_we = 1'b1; nl_addr = hit_q[AW-1:0]; nl_wd = free_q;
				end
			end
			ST_FRD: begin
				nl_addr = free_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			bkt_q <= '0;
			free_q <= NULLN;
			fresh_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					bkt_q <= bkt_q + 1'b1;
					if (bkt_q == BW'(BUCKETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd; key_q <= key; state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					bkt_q <= hmix[BW-1:0];
					state_q <= ST_HRD;
				end
				ST_HRD: state_q <= ST_HWAIT;
				ST_HWAIT: begin
					cur_q <= hb_rd; prev_q <= NULLN; steps_q <= '0;
					found_q <= 1'b0; chg_q <= 1'b0; full_q <= 1'b0;
					state_q <= ST_NRD;
				end
				ST_NRD: begin
					if (cur_q >= NULLN || steps_q >= (NW+1)'(NODES)) begin
						// allocation on add miss: pick node before ST_ACT
						if (is_add && free_q != NULLN) begin
							newn_q <= free_q; state_q <= ST_FRD;
						end else begin
							state_q <= ST_ACT;
							if (is_add) begin
								if (fresh_q != NULLN) begin
									newn_q <= fresh_q; fresh_q <= fresh_q + 1'b1;
								end else begin
									newn_q <= NULLN;
								end
							end
						end
					end else begin
						state_q <= ST_NCMP;
					end
				end
				ST_NCMP: begin
					if (nk_rd == key_q) begin
						found_q <= 1'b1; hit_q <= cur_q; nxt_q <= nl_rd;
						state_q <= ST_ACT;
					end else begin
						prev_q <= cur_q; cur_q <= nl_rd;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_NRD;
					end
				end
				ST_ACT: begin
					if (is_add && !found_q) begin
						if (newn_q == NULLN) begin
							full_q <= 1'b1; state_q <= ST_DONE;
						end else begin
							chg_q <= 1'b1;
							if (cnt_q < 13'(NODES)) cnt_q <= cnt_q + 1'b1;
							state_q <= ST_WR2;
						end
					end else if (is_rem && found_q) begin
						chg_q <= 1'b1;
						if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
						state_q <= ST_WR2;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WR2: begin
					if (!is_add) free_q <= hit_q;
					state_q <= ST_DONE;
				end
				ST_FRD: state_q <= ST_FWAIT;
				ST_FWAIT: begin
					free_q <= nl_rd;
					state_q <= ST_ACT;
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign found = found_q;
	assign changed = chg_q;
	assign full_res = full_q;
	assign entry_count = cnt_q;

	`CHS_ASSERT_IMP(a_full_add, clk, arst_n, done && full_q, is_add && !chg_q && !found_q, "full on non-add")
	`CHS_ASSERT_IMP(a_chg_found, clk, arst_n, done && chg_q && is_rem, found_q, "remove without hit")
	`CHS_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !done, "done longer than one cycle")

endmodule

`default_nettype wire

@@ hdl/chs_ram.sv @@
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read before write, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

@@ bench/chained_hash_set_engine_test.sv @@
// ----------------------------------------------------------------------------
// chained_hash_set_engine_test
// Drives add, remove, membership and spare-code items into the hash set engine and
// checks every result against a behavioral copy of the set kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_set_engine_test;

	localparam int NBKT = 1024;
	localparam int NPOOL = 4096;
	localparam int NIL = NPOOL;
	localparam logic [1:0] CMD_TEST = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0] op;
		logic [63:0] k;
	} req_t;

	typedef struct packed {
		logic found;
		logic changed;
		logic full;
		logic [12:0] count;
	} res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] cmd;
	logic [63:0] key;
	logic done;
	logic found;
	logic changed;
	logic full_res;
	logic [12:0] entry_count;

	chained_hash_set_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .key(key),
		.done(done), .found(found), .changed(changed), .full_res(full_res),
		.entry_count(entry_count)
	);

	// shadow copy of the set
	int chain_head [NBKT];
	logic [63:0] slot_key [NPOOL];
	int slot_link [NPOOL];
	int recycled_head;
	int fresh_used;
	int set_size;

	req_t pending_items [$];
	res_t expected_results [$];
	logic [63:0] live_keys [$];
	int errors;
	int cycles;
	int idle_left;
	bit quiet_mode;

	always #10 clk = ~clk;

	function automatic logic [31:0] remix(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 15) ^ (h >> 23);
		return t ^ (t >> 7) ^ (t >> 5);
	endfunction

	function automatic int bucket_index(input logic [63:0] k);
		logic [31:0] x;
		x = remix(k[63:32]) ^ remix(k[31:0]);
		return int'(x[9:0]);
	endfunction

	// apply one item to the shadow set and give the result it must produce
	function automatic res_t apply_item(input req_t it);
		res_t r;
		int b, cur, prev, hit, steps, n;
		b = bucket_index(it.k);
		cur = chain_head[b];
		prev = NIL;
		hit = NIL;
		steps = 0;
		while (cur < NPOOL && steps < NPOOL && hit == NIL) begin
			if (slot_key[cur] == it.k) begin
				hit = cur;
			end else begin
				prev = cur;
				cur = slot_link[cur];
				steps++;
			end
		end
		r = '0;
		r.found = (hit != NIL);
		if (it.op == chs_pkg::CMD_ADD && hit == NIL) begin
			n = NIL;
			if (recycled_head < NPOOL) begin
				n = recycled_head;
				recycled_head = slot_link[n];
			end else if (fresh_used < NPOOL) begin
				n = fresh_used;
				fresh_used++;
			end
			if (n == NIL) begin
				r.full = 1'b1;
			end else begin
				slot_key[n] = it.k;
				slot_link[n] = NIL;
				if (prev == NIL) chain_head[b] = n;
				else slot_link[prev] = n;
				set_size++;
				r.changed = 1'b1;
			end
		end else if (it.op == chs_pkg::CMD_REMOVE && hit != NIL) begin
			if (prev == NIL) chain_head[b] = slot_link[hit];
			else slot_link[prev] = slot_link[hit];
			slot_link[hit] = recycled_head;
			recycled_head = hit;
			set_size--;
			r.changed = 1'b1;
		end
		r.count = set_size[12:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// keys drawn from a small set of 256: only the low 8 bits vary
	function automatic logic [63:0] crowded_key();
		return {32'h0, 22'h0, 10'($urandom_range(0, 255))};
	endfunction

	function automatic logic [63:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && live_keys.size() > 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		else if (sel < 7)
			return crowded_key();
		return rand64();
	endfunction

	task automatic push_item(input logic [1:0] op, input logic [63:0] k);
		req_t it;
		it.op = op;
		it.k = k;
		pending_items.push_back(it);
		if (op == chs_pkg::CMD_ADD && live_keys.size() < 4000) live_keys.push_back(k);
	endtask

	// driver: presents items at the falling edge, holds start until accepted
	logic accepted;
	always @(posedge clk) begin
		accepted <= start && !busy && arst_n;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || accepted) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req_t it;
					it = pending_items.pop_front();
					cmd <= it.op;
					key <= it.k;
					start <= 1'b1;
					expected_results.push_back(apply_item(it));
					if (!quiet_mode && $urandom_range(0, 7) == 0)
						idle_left <= $urandom_range(1, 19);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: one result per done strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			res_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(entry_count), 64'h0);
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found)
					report_mismatch("found", 64'(found), 64'(want.found));
				if (changed !== want.changed)
					report_mismatch("changed", 64'(changed), 64'(want.changed));
				if (full_res !== want.full)
					report_mismatch("full_res", 64'(full_res), 64'(want.full));
				if (entry_count !== want.count)
					report_mismatch("entry_count", 64'(entry_count), 64'(want.count));
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("chained_hash_set_engine_test: FAIL");
			$finish;
		end
	end

	initial begin
		int i, b;
		logic [63:0] k;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_TEST;
		key = '0;
		errors = 0;
		cycles = 0;
		idle_left = 0;
		quiet_mode = 1'b0;
		for (i = 0; i < NBKT; i++) chain_head[i] = NIL;
		for (i = 0; i < NPOOL; i++) begin
			slot_key[i] = '0;
			slot_link[i] = NIL;
		end
		recycled_head = NIL;
		fresh_used = 0;
		set_size = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, duplicates, absent keys, spare code
		push_item(CMD_TEST, 64'h0);
		push_item(chs_pkg::CMD_REMOVE, 64'h0);
		push_item(chs_pkg::CMD_ADD, 64'h0);
		push_item(chs_pkg::CMD_ADD, 64'h0);
		push_item(chs_pkg::CMD_ADD, '1);
		push_item(CMD_TEST, '1);
		push_item(CMD_SPARE, '1);
		push_item(CMD_SPARE, 64'h5);
		push_item(chs_pkg::CMD_ADD, 64'hffffffff_00000000);
		push_item(chs_pkg::CMD_ADD, 64'h00000000_ffffffff);
		push_item(chs_pkg::CMD_ADD, 64'haaaaaaaa_55555555);
		push_item(chs_pkg::CMD_ADD, 64'h55555555_aaaaaaaa);
		push_item(chs_pkg::CMD_ADD, 64'h1);
		push_item(chs_pkg::CMD_ADD, 64'h2);
		push_item(chs_pkg::CMD_REMOVE, 64'h1);
		push_item(chs_pkg::CMD_REMOVE, 64'h1);
		push_item(CMD_TEST, 64'h2);
		push_item(chs_pkg::CMD_REMOVE, '1);
		push_item(chs_pkg::CMD_ADD, 64'h1);
		push_item(chs_pkg::CMD_REMOVE, 64'h0);

		// random mix biased toward keys already used
		for (i = 0; i < 660; i++) begin
			b = $urandom_range(0, 9);
			k = pick_key();
			if (b < 4) push_item(chs_pkg::CMD_ADD, k);
			else if (b < 7) push_item(chs_pkg::CMD_REMOVE, k);
			else if (b < 9) push_item(CMD_TEST, k);
			else push_item(CMD_SPARE, k);
		end
		wait (pending_items.size() == 0);

		// burst of fresh adds, then a mixed tail
		for (i = 0; i < 60; i++) push_item(chs_pkg::CMD_ADD, {32'hc0de0000 + i, $urandom()});
		push_item(chs_pkg::CMD_ADD, 64'h1);
		for (i = 0; i < 60; i++) begin
			k = pick_key();
			push_item(i % 3 == 0 ? chs_pkg::CMD_ADD :
				(i % 3 == 1 ? chs_pkg::CMD_REMOVE : CMD_TEST), k);
		end
		wait (pending_items.size() < 40);
		quiet_mode = 1'b1;
		wait (pending_items.size() == 0);
		@(negedge clk);
		wait (expected_results.size() == 0 && !busy);
		repeat (64) @(posedge clk);
		if (errors == 0) begin
			$display("chained_hash_set_engine_test: PASS");
		end else begin
			$display("chained_hash_set_engine_test: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/chs_pkg.sv
hdl/chs_ram.sv
hdl/chained_hash_set_engine.sv
bench/chained_hash_set_engine_test.sv
